[design/dts_pkg.sv]
package dts_pkg;

   localparam int ID_BITS          = 6;
   localparam int ID_SPACE         = 64;
   localparam int CHAN_IN_BITS     = 32;
   localparam int FUNC_BITS        = 3;
   localparam int STATUS_BITS      = 2;
   localparam int MAX_THREADS_DEF  = 64;
   localparam int CHAN_BITS_DEF    = 32;

   typedef logic [ID_BITS-1:0]     id_type;
   typedef logic [FUNC_BITS-1:0]   func_type;
   typedef logic [STATUS_BITS-1:0] status_type;

   localparam func_type FUNC_PUT_TURN   = 3'd0;
   localparam func_type FUNC_WAIT       = 3'd1;
   localparam func_type FUNC_SIGNAL     = 3'd2;
   localparam func_type FUNC_END_THREAD = 3'd3;
   localparam func_type FUNC_CREATE     = 3'd4;

   localparam status_type ST_OK         = 2'd0;
   localparam status_type ST_NOT_HOLDER = 2'd1;
   localparam status_type ST_WAITING    = 2'd2;
   localparam status_type ST_FULL       = 2'd3;

endpackage

[design/dts_req_if.sv]
interface dts_req_if
   import dts_pkg::*;
   ();
   logic        valid;
   logic        ready;
   func_type    func;
   id_type      thread_id;
   logic [CHAN_IN_BITS-1:0] chan;
   id_type      new_thread;

   modport source (output valid, func, thread_id, chan, new_thread, input ready);
   modport sink (input valid, func, thread_id, chan, new_thread, output ready);
endinterface

[design/dts_rsp_if.sv]
interface dts_rsp_if
   import dts_pkg::*;
   ();
   logic       valid;
   logic       ready;
   logic       turn_valid;
   id_type     turn_holder;
   logic       woken_valid;
   id_type     woken_thread;
   status_type status;

   modport source (output valid, turn_valid, turn_holder, woken_valid, woken_thread,
                   status, input ready);
   modport sink (input valid, turn_valid, turn_holder, woken_valid, woken_thread,
                 status, output ready);
endinterface

[design/deterministic_turn_scheduler.sv]
// Channel   Direction  Contents
// req_chan  in         func, thread_id, chan, new_thread
// rsp_chan  out        turn_valid, turn_holder, woken_valid, woken_thread, status
//
// Put, wait, create and undefined requests pass through decide, finish and output.
// A signal, or an end_thread from the holder, scans the wait list through the list
// memory and the channel tag memory, then compacts the list behind a woken thread.
// Reset is synchronous and empties both lists and clears every wait mark at once.
// A new item is taken only in the idle state, also while a result waits to be taken.
module deterministic_turn_scheduler
   import dts_pkg::*;
   #(
      parameter int MAX_THREADS = MAX_THREADS_DEF,
      parameter int CHAN_BITS   = CHAN_BITS_DEF
   )
   (
      input logic      clock,
      input logic      reset,
      dts_req_if.sink   req_chan,
      dts_rsp_if.source rsp_chan
   );

   localparam int IW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
   localparam int CW = $clog2(MAX_THREADS + 1);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_DECIDE   = 7'b0000010,
      S_SCAN_ID  = 7'b0000100,
      S_SCAN_CMP = 7'b0001000,
      S_SHIFT    = 7'b0010000,
      S_FIN      = 7'b0100000,
      S_OUT      = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   func_type  func_ff, func_in;
   id_type    tid_ff, tid_in;
   id_type    nt_ff, nt_in;
   logic [CHAN_BITS-1:0] ch_ff, ch_in;
   logic [IW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] wcount_ff, wcount_in;
   logic [IW-1:0] idx_ff, idx_in;
   id_type    tag_ff, tag_in;
   status_type status_ff, status_in;
   logic      woke_ff, woke_in;
   id_type    who_ff, who_in;
   logic [ID_SPACE-1:0] waiting_ff, waiting_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_turn_valid_ff, rsp_turn_valid_in;
   id_type     rsp_holder_ff, rsp_holder_in;
   logic       rsp_woken_valid_ff, rsp_woken_valid_in;
   id_type     rsp_woken_ff, rsp_woken_in;
   status_type rsp_status_ff, rsp_status_in;

   id_type act_mem [MAX_THREADS];
   id_type act_rd_ff;
   logic   act_we;
   logic [IW-1:0] act_waddr;
   id_type act_wdata;

   id_type wl_mem [MAX_THREADS];
   id_type wl_rd_ff;
   logic   wl_we;
   logic [IW-1:0] wl_waddr;
   id_type wl_wdata;
   logic [IW-1:0] wl_raddr;

   logic [CHAN_BITS-1:0] wc_mem [ID_SPACE];
   logic [CHAN_BITS-1:0] wc_rd_ff;
   logic   wc_we;

   logic          holder;
   logic          act_full;
   logic [CW:0]   tail_sum;
   logic [IW-1:0] tail_addr;
   logic [IW-1:0] head_next;
   logic [CW-1:0] idx_wide;
   logic          load_rsp;

   always_comb begin
      holder    = (count_ff != '0) && (act_rd_ff == tid_ff);
      act_full  = (count_ff == CW'(MAX_THREADS));
      tail_sum  = (CW+1)'(head_ff) + (CW+1)'(count_ff);
      if (tail_sum >= (CW+1)'(MAX_THREADS)) begin
         tail_sum = tail_sum - (CW+1)'(MAX_THREADS);
      end
      tail_addr = tail_sum[IW-1:0];
      head_next = (head_ff == IW'(MAX_THREADS - 1)) ? '0 : head_ff + IW'(1);
      idx_wide  = CW'(idx_ff);
      load_rsp  = !rsp_valid_ff || rsp_chan.ready;
   end

   always_comb begin
      state_in   = state_ff;
      func_in    = func_ff;
      tid_in     = tid_ff;
      nt_in      = nt_ff;
      ch_in      = ch_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      wcount_in  = wcount_ff;
      idx_in     = idx_ff;
      tag_in     = tag_ff;
      status_in  = status_ff;
      woke_in    = woke_ff;
      who_in     = who_ff;
      waiting_in = waiting_ff;

      rsp_valid_in       = rsp_valid_ff && !rsp_chan.ready;
      rsp_turn_valid_in  = rsp_turn_valid_ff;
      rsp_holder_in      = rsp_holder_ff;
      rsp_woken_valid_in = rsp_woken_valid_ff;
      rsp_woken_in       = rsp_woken_ff;
      rsp_status_in      = rsp_status_ff;

      act_we    = 1'b0;
      act_waddr = tail_addr;
      act_wdata = act_rd_ff;
      wl_we     = 1'b0;
      wl_waddr  = idx_ff;
      wl_wdata  = wl_rd_ff;
      wl_raddr  = '0;
      wc_we     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               func_in  = req_chan.func;
               tid_in   = req_chan.thread_id;
               nt_in    = req_chan.new_thread;
               ch_in    = CHAN_BITS'(req_chan.chan);
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            status_in = ST_OK;
            woke_in   = 1'b0;
            who_in    = '0;
            state_in  = S_FIN;
            case (func_ff)
               FUNC_PUT_TURN: begin
                  if (!holder) begin
                     status_in = ST_NOT_HOLDER;
                  end else begin
                     act_we    = 1'b1;
                     act_wdata = act_rd_ff;
                     head_in   = head_next;
                  end
               end
               FUNC_WAIT: begin
                  if (!holder) begin
                     status_in = ST_NOT_HOLDER;
                  end else if (waiting_ff[tid_ff]) begin
                     status_in = ST_WAITING;
                  end else if (wcount_ff == CW'(MAX_THREADS)) begin
                     status_in = ST_FULL;
                  end else begin
                     head_in    = head_next;
                     count_in   = count_ff - CW'(1);
                     wl_we      = 1'b1;
                     wl_waddr   = wcount_ff[IW-1:0];
                     wl_wdata   = tid_ff;
                     wcount_in  = wcount_ff + CW'(1);
                     wc_we      = 1'b1;
                     waiting_in[tid_ff] = 1'b1;
                  end
               end
               FUNC_SIGNAL: begin
                  idx_in   = '0;
                  state_in = (wcount_ff == '0) ? S_FIN : S_SCAN_ID;
               end
               FUNC_END_THREAD: begin
                  if (!holder) begin
                     status_in = ST_NOT_HOLDER;
                  end else begin
                     head_in  = head_next;
                     count_in = count_ff - CW'(1);
                     ch_in    = CHAN_BITS'(tid_ff);
                     idx_in   = '0;
                     state_in = (wcount_ff == '0) ? S_FIN : S_SCAN_ID;
                  end
               end
               FUNC_CREATE: begin
                  if ((count_ff != '0) && (act_rd_ff != tid_ff)) begin
                     status_in = ST_NOT_HOLDER;
                  end else if (act_full) begin
                     status_in = ST_FULL;
                  end else begin
                     act_we    = 1'b1;
                     act_wdata = nt_ff;
                     count_in  = count_ff + CW'(1);
                  end
               end
               default: begin
               end
            endcase
         end
         S_SCAN_ID: begin
            tag_in   = wl_rd_ff;
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (wc_rd_ff == ch_ff) begin
               if (act_full) begin
                  status_in = ST_FULL;
                  state_in  = S_FIN;
               end else begin
                  act_we     = 1'b1;
                  act_wdata  = tag_ff;
                  count_in   = count_ff + CW'(1);
                  waiting_in[tag_ff] = 1'b0;
                  woke_in    = 1'b1;
                  who_in     = tag_ff;
                  wcount_in  = wcount_ff - CW'(1);
                  if (idx_wide < wcount_ff - CW'(1)) begin
                     wl_raddr = IW'(idx_wide + CW'(1));
                     state_in = S_SHIFT;
                  end else begin
                     state_in = S_FIN;
                  end
               end
            end else if (idx_wide + CW'(1) < wcount_ff) begin
               idx_in   = idx_ff + IW'(1);
               wl_raddr = IW'(idx_wide + CW'(1));
               state_in = S_SCAN_ID;
            end else begin
               state_in = S_FIN;
            end
         end
         S_SHIFT: begin
            wl_we    = 1'b1;
            wl_waddr = idx_ff;
            wl_wdata = wl_rd_ff;
            if (idx_wide + CW'(1) < wcount_ff) begin
               idx_in   = idx_ff + IW'(1);
               wl_raddr = IW'(idx_wide + CW'(2));
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (load_rsp) begin
               rsp_valid_in       = 1'b1;
               rsp_turn_valid_in  = (count_ff != '0);
               rsp_holder_in      = (count_ff != '0) ? act_rd_ff : '0;
               rsp_woken_valid_in = woke_ff;
               rsp_woken_in       = woke_ff ? who_ff : '0;
               rsp_status_in      = status_ff;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         wcount_ff    <= '0;
         waiting_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         wcount_ff    <= wcount_in;
         waiting_ff   <= waiting_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff            <= func_in;
      tid_ff             <= tid_in;
      nt_ff              <= nt_in;
      ch_ff              <= ch_in;
      idx_ff             <= idx_in;
      tag_ff             <= tag_in;
      status_ff          <= status_in;
      woke_ff            <= woke_in;
      who_ff             <= who_in;
      rsp_turn_valid_ff  <= rsp_turn_valid_in;
      rsp_holder_ff      <= rsp_holder_in;
      rsp_woken_valid_ff <= rsp_woken_valid_in;
      rsp_woken_ff       <= rsp_woken_in;
      rsp_status_ff      <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (act_we) begin
         act_mem[act_waddr] <= act_wdata;
      end
      act_rd_ff <= act_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (wl_we) begin
         wl_mem[wl_waddr] <= wl_wdata;
      end
      wl_rd_ff <= wl_mem[wl_raddr];
   end

   always_ff @(posedge clock) begin
      if (wc_we) begin
         wc_mem[tid_ff] <= ch_ff;
      end
      wc_rd_ff <= wc_mem[wl_rd_ff];
   end

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.turn_valid   = rsp_turn_valid_ff;
   assign rsp_chan.turn_holder  = rsp_holder_ff;
   assign rsp_chan.woken_valid  = rsp_woken_valid_ff;
   assign rsp_chan.woken_thread = rsp_woken_ff;
   assign rsp_chan.status       = rsp_status_ff;

endmodule

[tb/sv/dts_turn_checker.sv]
module dts_turn_checker
   import dts_pkg::*;
   (
      input logic  clock,
      input logic  reset,
      dts_req_if   req_seen,
      dts_rsp_if   rsp_seen,
      output int   mismatches,
      output int   outstanding,
      output int   checked,
      output int   wakeups,
      output int   full_hits,
      output int   holder_misses,
      output int   rewaits
   );

   typedef struct packed {
      logic       turn_valid;
      id_type     turn_holder;
      logic       woken_valid;
      id_type     woken_thread;
      status_type status;
   } turn_report_type;

   id_type                  run_queue [$];
   id_type                  sleepers [$];
   logic [CHAN_IN_BITS-1:0] sleep_chan [ID_SPACE];
   logic                    sleeping [ID_SPACE];
   turn_report_type         due_reports [$];
   turn_report_type         oldest;
   turn_report_type         fresh;

   task automatic report(input string text);
      $display("dts_turn_checker: %s", text);
      mismatches++;
   endtask

   task automatic compare_field(input string name, input int got, input int want);
      if (got != want) begin
         report($sformatf("item %0d field %s: got %0d, expected %0d",
                          checked, name, got, want));
      end
   endtask

   function automatic logic holds_turn(input id_type tid);
      return run_queue.size() > 0 && run_queue[0] == tid;
   endfunction

   // Moves the first sleeper tagged with ch to the tail of the run queue, unless the run queue is full.
   function automatic status_type wake_sleeper(input logic [CHAN_IN_BITS-1:0] ch,
                                               output logic woke, output id_type who);
      woke = 1'b0;
      who = '0;
      for (int i = 0; i < sleepers.size(); i++) begin
         if (sleep_chan[sleepers[i]] == ch) begin
            if (run_queue.size() >= MAX_THREADS_DEF) begin
               return ST_FULL;
            end
            who = sleepers[i];
            sleepers.delete(i);
            sleeping[who] = 1'b0;
            run_queue = {run_queue, who};
            woke = 1'b1;
            return ST_OK;
         end
      end
      return ST_OK;
   endfunction

   function automatic turn_report_type apply_request(input func_type op, input id_type tid,
                                                     input logic [CHAN_IN_BITS-1:0] ch,
                                                     input id_type nt);
      turn_report_type         r;
      logic                    woke;
      id_type                  who;
      id_type                  rotated;
      status_type              st;
      logic [CHAN_IN_BITS-1:0] id_chan;
      woke = 1'b0;
      who = '0;
      st = ST_OK;
      id_chan = CHAN_IN_BITS'(tid);
      case (op)
         FUNC_PUT_TURN: begin
            if (!holds_turn(tid)) begin
               st = ST_NOT_HOLDER;
            end else begin
               rotated = run_queue[0];
               run_queue.delete(0);
               run_queue = {run_queue, rotated};
            end
         end
         FUNC_WAIT: begin
            if (!holds_turn(tid)) begin
               st = ST_NOT_HOLDER;
            end else if (sleeping[tid]) begin
               st = ST_WAITING;
            end else if (sleepers.size() >= MAX_THREADS_DEF) begin
               st = ST_FULL;
            end else begin
               run_queue.delete(0);
               sleepers = {sleepers, tid};
               sleep_chan[tid] = ch;
               sleeping[tid] = 1'b1;
            end
         end
         FUNC_SIGNAL: begin
            st = wake_sleeper(ch, woke, who);
         end
         FUNC_END_THREAD: begin
            if (!holds_turn(tid)) begin
               st = ST_NOT_HOLDER;
            end else begin
               run_queue.delete(0);
               st = wake_sleeper(id_chan, woke, who);
            end
         end
         FUNC_CREATE: begin
            if (run_queue.size() > 0 && run_queue[0] != tid) begin
               st = ST_NOT_HOLDER;
            end else if (run_queue.size() >= MAX_THREADS_DEF) begin
               st = ST_FULL;
            end else begin
               run_queue = {run_queue, nt};
            end
         end
         default: begin
         end
      endcase
      r.turn_valid = run_queue.size() > 0;
      r.turn_holder = run_queue.size() > 0 ? run_queue[0] : id_type'(0);
      r.woken_valid = woke;
      r.woken_thread = woke ? who : id_type'(0);
      r.status = st;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         run_queue.delete();
         sleepers.delete();
         due_reports.delete();
         for (int k = 0; k < ID_SPACE; k++) begin
            sleeping[k] = 1'b0;
            sleep_chan[k] = '0;
         end
         mismatches = 0;
         outstanding = 0;
         checked = 0;
         wakeups = 0;
         full_hits = 0;
         holder_misses = 0;
         rewaits = 0;
      end else begin
         // A result never belongs to an item taken at the same edge.
         if (rsp_seen.valid && rsp_seen.ready) begin
            if (due_reports.size() == 0) begin
               report($sformatf("result with no item pending (holder %0d, status %0d)",
                                rsp_seen.turn_holder, rsp_seen.status));
            end else begin
               oldest = due_reports[0];
               due_reports.delete(0);
               compare_field("turn_valid", int'(rsp_seen.turn_valid),
                             int'(oldest.turn_valid));
               compare_field("turn_holder", int'(rsp_seen.turn_holder),
                             int'(oldest.turn_holder));
               compare_field("woken_valid", int'(rsp_seen.woken_valid),
                             int'(oldest.woken_valid));
               compare_field("woken_thread", int'(rsp_seen.woken_thread),
                             int'(oldest.woken_thread));
               compare_field("status", int'(rsp_seen.status), int'(oldest.status));
               checked++;
            end
         end
         if (req_seen.valid && req_seen.ready) begin
            fresh = apply_request(req_seen.func, req_seen.thread_id, req_seen.chan,
                                  req_seen.new_thread);
            due_reports = {due_reports, fresh};
            if (fresh.woken_valid) begin
               wakeups++;
            end
            case (fresh.status)
               ST_FULL: full_hits++;
               ST_NOT_HOLDER: holder_misses++;
               ST_WAITING: rewaits++;
               default: begin
               end
            endcase
         end
         outstanding = due_reports.size();
      end
   end

endmodule

[tb/sv/tb_deterministic_turn_scheduler.sv]
module tb_deterministic_turn_scheduler;
   import dts_pkg::*;

   localparam int RESET_CYCLES = 10;
   localparam int CYCLE_LIMIT  = 2_500_000;
   localparam int TAIL_CYCLES  = 3 * MAX_THREADS_DEF + 8;
   localparam int RANDOM_ITEMS = 1850;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = RANDOM_ITEMS / PHASES;

   localparam func_type FUNC_SPARE_5 = 3'd5;
   localparam func_type FUNC_SPARE_6 = 3'd6;
   localparam func_type FUNC_SPARE_7 = 3'd7;

   localparam logic [CHAN_IN_BITS-1:0] CHAN_ZERO = '0;
   localparam logic [CHAN_IN_BITS-1:0] CHAN_ONES = '1;
   localparam logic [CHAN_IN_BITS-1:0] CHAN_HIGH = 32'h8000_0000;
   localparam logic [CHAN_IN_BITS-1:0] CHAN_LOW  = 32'h7FFF_FFFF;

   typedef enum int {MIX_BALANCED, MIX_FILL, MIX_SLEEP, MIX_WAKE, MIX_DRAIN} mix_type;

   logic   clock;
   logic   reset;
   int     cycles;
   int     sent;
   int     stall_left;
   logic   calm;
   logic   seen_active;
   id_type seen_holder;
   logic [CHAN_IN_BITS-1:0] recent_waits [8];
   int     wait_slot;

   int mismatches, outstanding, checked, wakeups, full_hits, holder_misses, rewaits;

   dts_req_if req_chan ();
   dts_rsp_if rsp_chan ();

   deterministic_turn_scheduler DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   dts_turn_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_seen      (req_chan),
      .rsp_seen      (rsp_chan),
      .mismatches    (mismatches),
      .outstanding   (outstanding),
      .checked       (checked),
      .wakeups       (wakeups),
      .full_hits     (full_hits),
      .holder_misses (holder_misses),
      .rewaits       (rewaits)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_deterministic_turn_scheduler: errors");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left <= 0;
         seen_active <= 1'b0;
         seen_holder <= '0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen_active <= rsp_chan.turn_valid;
            seen_holder <= rsp_chan.turn_holder;
         end
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left <= stall_left - 1;
         end else if (!calm && $urandom_range(0, 99) < 25) begin
            rsp_chan.ready <= 1'b0;
            stall_left <= pick_gap();
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic wait_drained();
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   // Lowers valid only when time has to pass before the next item.
   task automatic hold_off(input logic drain);
      int gap;
      gap = calm ? 0 : pick_gap();
      if (drain || gap > 0) begin
         req_chan.valid <= 1'b0;
         if (drain) begin
            wait_drained();
         end
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic offer(input func_type op, input id_type tid,
                        input logic [CHAN_IN_BITS-1:0] ch, input id_type nt);
      req_chan.valid <= 1'b1;
      req_chan.func <= op;
      req_chan.thread_id <= tid;
      req_chan.chan <= ch;
      req_chan.new_thread <= nt;
      do @(posedge clock); while (!req_chan.ready);
      sent++;
   endtask

   task automatic directed(input func_type op, input id_type tid,
                           input logic [CHAN_IN_BITS-1:0] ch, input id_type nt);
      hold_off($urandom_range(0, 1));
      offer(op, tid, ch, nt);
   endtask

   function automatic func_type pick_op(input mix_type mix);
      int       w [5];
      int       total;
      int       r;
      func_type ops [5];
      ops = '{FUNC_PUT_TURN, FUNC_WAIT, FUNC_SIGNAL, FUNC_END_THREAD, FUNC_CREATE};
      if ($urandom_range(0, 99) < 4) begin
         case ($urandom_range(0, 2))
            0: return FUNC_SPARE_5;
            1: return FUNC_SPARE_6;
            default: return FUNC_SPARE_7;
         endcase
      end
      case (mix)
         MIX_FILL: w = '{15, 8, 10, 5, 58};
         MIX_SLEEP: w = '{20, 45, 10, 5, 16};
         MIX_WAKE: w = '{20, 10, 45, 10, 15};
         MIX_DRAIN: w = '{20, 5, 20, 45, 10};
         default: w = '{24, 20, 20, 12, 20};
      endcase
      total = 0;
      foreach (w[i]) total += w[i];
      r = $urandom_range(0, total - 1);
      foreach (w[i]) begin
         if (r < w[i]) return ops[i];
         r -= w[i];
      end
      return FUNC_PUT_TURN;
   endfunction

   function automatic logic [CHAN_IN_BITS-1:0] pick_pool_chan();
      case ($urandom_range(0, 3))
         0: return CHAN_ZERO;
         1: return CHAN_ONES;
         2: return CHAN_HIGH;
         default: return CHAN_LOW;
      endcase
   endfunction

   task automatic random_item(input mix_type mix);
      func_type                op;
      id_type                  tid;
      id_type                  nt;
      logic [CHAN_IN_BITS-1:0] ch;
      int                      r;
      hold_off($urandom_range(0, 99) < 85);
      op = pick_op(mix);
      tid = (seen_active && $urandom_range(0, 99) < 85) ? seen_holder
                                                         : id_type'($urandom_range(0, 63));
      nt = ($urandom_range(0, 99) < 30) ? seen_holder : id_type'($urandom_range(0, 63));
      ch = $urandom();
      r = $urandom_range(0, 99);
      if (op == FUNC_WAIT) begin
         if (r < 40) ch = $urandom_range(0, 63);
         else if (r < 75) ch = pick_pool_chan();
         recent_waits[wait_slot] = ch;
         wait_slot = (wait_slot + 1) % 8;
      end else if (op == FUNC_SIGNAL) begin
         if (r < 50) ch = recent_waits[$urandom_range(0, 7)];
         else if (r < 70) ch = $urandom_range(0, 63);
         else if (r < 80) ch = pick_pool_chan();
      end
      offer(op, tid, ch, nt);
   endtask

   initial begin
      reset <= 1'b1;
      calm <= 1'b0;
      cycles <= 0;
      sent = 0;
      wait_slot = 0;
      foreach (recent_waits[i]) recent_waits[i] = '0;
      req_chan.valid <= 1'b0;
      req_chan.func <= FUNC_PUT_TURN;
      req_chan.thread_id <= '0;
      req_chan.chan <= '0;
      req_chan.new_thread <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty scheduler, spare function codes, then duplicate ids, waiting and waking.
      directed(FUNC_PUT_TURN, 6'd0, CHAN_ZERO, 6'd0);
      directed(FUNC_WAIT, 6'd0, CHAN_ZERO, 6'd0);
      directed(FUNC_END_THREAD, 6'd63, CHAN_ONES, 6'd63);
      directed(FUNC_SIGNAL, 6'd0, CHAN_ZERO, 6'd0);
      directed(FUNC_SPARE_5, 6'd63, CHAN_ONES, 6'd63);
      directed(FUNC_SPARE_6, 6'd0, CHAN_HIGH, 6'd0);
      directed(FUNC_SPARE_7, 6'd63, CHAN_LOW, 6'd63);
      directed(FUNC_CREATE, 6'd17, CHAN_ZERO, 6'd63);
      directed(FUNC_CREATE, 6'd5, CHAN_ZERO, 6'd0);
      directed(FUNC_CREATE, 6'd63, CHAN_ZERO, 6'd63);
      directed(FUNC_CREATE, 6'd63, CHAN_ZERO, 6'd1);
      directed(FUNC_PUT_TURN, 6'd63, CHAN_ZERO, 6'd0);
      directed(FUNC_WAIT, 6'd63, CHAN_ONES, 6'd0);
      directed(FUNC_PUT_TURN, 6'd1, CHAN_ZERO, 6'd0);
      directed(FUNC_WAIT, 6'd63, 32'd5, 6'd0);
      directed(FUNC_SIGNAL, 6'd0, CHAN_LOW, 6'd0);
      directed(FUNC_SIGNAL, 6'd0, CHAN_ONES, 6'd0);
      directed(FUNC_PUT_TURN, 6'd63, CHAN_ZERO, 6'd0);
      directed(FUNC_WAIT, 6'd1, 32'd63, 6'd0);
      directed(FUNC_END_THREAD, 6'd2, CHAN_ZERO, 6'd0);
      directed(FUNC_END_THREAD, 6'd63, CHAN_ZERO, 6'd0);
      directed(FUNC_CREATE, 6'd63, CHAN_ZERO, 6'd0);
      directed(FUNC_END_THREAD, 6'd63, CHAN_ZERO, 6'd0);
      directed(FUNC_END_THREAD, 6'd1, CHAN_ZERO, 6'd0);
      directed(FUNC_END_THREAD, 6'd0, CHAN_ONES, 6'd0);

      // The sender stops here until every result of the directed items is back.
      req_chan.valid <= 1'b0;
      wait_drained();

      for (int p = 0; p < PHASES; p++) begin
         calm <= ($urandom_range(0, 3) == 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            random_item(mix_type'(p % 5));
         end
      end

      req_chan.valid <= 1'b0;
      calm <= 1'b0;
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d items and %0d results: %0d wakeups, %0d list-full,",
               sent, checked, wakeups, full_hits);
      $display("  %0d not-holder and %0d already-waiting outcomes.", holder_misses, rewaits);
      if (mismatches == 0 && outstanding == 0) begin
         $display("tb_deterministic_turn_scheduler: clean");
      end else begin
         $display("tb_deterministic_turn_scheduler: errors");
      end
      $finish;
   end

endmodule

[filelist.f]
design/dts_pkg.sv
design/dts_req_if.sv
design/dts_rsp_if.sv
design/deterministic_turn_scheduler.sv
tb/sv/dts_turn_checker.sv
tb/sv/tb_deterministic_turn_scheduler.sv
